// ===== hw/rtl/adq_pkg.sv =====
// Shared types and constants for the array deque with search.
// No dependencies; imported by adq_core, array_deque_with_search and tb_top.
package adq_pkg;

    localparam int DEPTH   = 16;
    localparam int ELEM_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 5;
    localparam int ACT_W   = 4;
    localparam int STAT_W  = 2;

    typedef logic signed [POS_W-1:0] t_pos;

    localparam t_pos NO_POS = -t_pos'(1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_HEAD  = 4'd0,
        ACT_ADD_TAIL  = 4'd1,
        ACT_REM_HEAD  = 4'd2,
        ACT_REM_TAIL  = 4'd3,
        ACT_REM_VAL   = 4'd4,
        ACT_HAS_VAL   = 4'd5,
        ACT_PEEK_HEAD = 4'd6,
        ACT_PEEK_TAIL = 4'd7,
        ACT_ENUM      = 4'd8
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOROOM   = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [ELEM_W-1:0]   value;
        t_pos                pos;
        logic                last;
        logic                is_empty;
        logic                is_full;
        logic [CNT_W-1:0]    occupancy;
    } t_result;

endpackage

// ===== hw/rtl/array_deque_with_search.sv =====
// Top level of the array deque with search: stream ports, output register.
// Depends on adq_pkg and adq_core.
//
// Usage:
//   s_axis carries one action per item: action and element word. Each action
//   produces one result on m_axis with tlast high, except enumerate, which
//   gives one result per entry (head first, tlast low) and then a terminator
//   (position -1, tlast high).
//   i_cfg_we/i_cfg_wdata write the capacity (1..16, larger saturates, zero is
//   ignored) and empty the list; write only while no item is in flight.
//   An item passes an accept state and a dispatch state, then walks the slot
//   RAM a slot at a time (shift, search or enumeration, up to 16 slots), then
//   hands off the result. Enumerate hands off one entry per walk cycle while
//   the receiver takes them. A result shows on m_axis in the cycle after the
//   core hands it to the output register. The next item is taken once the
//   previous item's last result sits in the output register.
//   Reset empties the list and sets capacity to 16; slot contents are not
//   cleared. A stalled receiver holds the output register and the core waits.
module array_deque_with_search
    import adq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[3:0], element[35:4], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status[1:0], value[33:2], position[38:34],
                                       // is_empty[39], is_full[40], occupancy[45:41]
    output logic        m_axis_tlast
);

    logic    res_valid, res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    adq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tdata[ACT_W-1:0]),
        .i_element   (s_axis_tdata[ACT_W +: ELEM_W]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {2'b00, r_out.occupancy, r_out.is_full, r_out.is_empty,
                            r_out.pos, r_out.value, r_out.status};

endmodule

// ===== hw/rtl/adq_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data registered. No dependencies.
module adq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/adq_core.sv =====
// Sequencer for the deque: count/capacity registers and slot RAM walks.
// Depends on adq_pkg and adq_ram.
module adq_core
    import adq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ELEM_W-1:0] i_element,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_UP, S_HEAD, S_DOWN, S_SRCH, S_RDW, S_ENUM, S_EMIT
    } t_state;

    t_state             r_state, n_state;
    t_action            r_act, n_act;
    logic [ELEM_W-1:0]  r_elem, n_elem;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cap, n_cap;
    t_status            r_status, n_status;
    logic [ELEM_W-1:0]  r_value, n_value;
    t_pos               r_pos, n_pos;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [ELEM_W-1:0]  ram_wdata, ram_rdata;

    logic [CNT_W-1:0]   cfg_sat;
    logic [CNT_W-1:0]   idx_p1;
    logic               full, empty;

    adq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cfg_sat = (i_cfg_wdata > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : i_cfg_wdata;
    assign idx_p1  = {1'b0, r_idx} + CNT_W'(1);
    assign full    = (r_count >= r_cap);
    assign empty   = (r_count == '0);

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_elem    = r_elem;
        n_idx     = r_idx;
        n_count   = r_count;
        n_cap     = r_cap;
        n_status  = r_status;
        n_value   = r_value;
        n_pos     = r_pos;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we && (i_cfg_wdata != '0)) begin
                    n_cap   = cfg_sat;
                    n_count = '0;
                end
                if (i_valid) begin
                    n_act   = t_action'(i_action);
                    n_elem  = i_element;
                    n_state = S_START;
                end
            end
            S_START: begin
                // default answer: not found
                n_status = ST_NOTFOUND;
                n_value  = '0;
                n_pos    = NO_POS;
                n_state  = S_EMIT;
                case (r_act)
                    ACT_ADD_HEAD, ACT_ADD_TAIL: begin
                        if (full) begin
                            n_status = ST_NOROOM;
                        end else if (r_act == ACT_ADD_TAIL) begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(r_count);
                            ram_wdata = r_elem;
                            n_count   = r_count + CNT_W'(1);
                            n_status  = ST_OK;
                            n_pos     = t_pos'(r_count);
                        end else if (empty) begin
                            n_state = S_HEAD;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                            n_idx     = ADDR_W'(r_count - CNT_W'(1));
                            n_state   = S_UP;
                        end
                    end
                    ACT_REM_HEAD, ACT_PEEK_HEAD: begin
                        if (!empty) begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_RDW;
                        end
                    end
                    ACT_REM_TAIL, ACT_PEEK_TAIL: begin
                        if (!empty) begin
                            ram_re    = 1'b1;
                            ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                            n_idx     = ADDR_W'(r_count - CNT_W'(1));
                            n_state   = S_RDW;
                        end
                    end
                    ACT_REM_VAL, ACT_HAS_VAL: begin
                        if (!empty) begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_SRCH;
                        end
                    end
                    ACT_ENUM: begin
                        if (empty) begin
                            n_status = ST_OK;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_ENUM;
                        end
                    end
                    default: ;
                endcase
            end
            S_UP: begin
                // ram_rdata is slot[r_idx]; move it up one slot
                ram_we    = 1'b1;
                ram_waddr = r_idx + ADDR_W'(1);
                if (r_idx != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx - ADDR_W'(1);
                    n_idx     = r_idx - ADDR_W'(1);
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_elem;
                n_count   = r_count + CNT_W'(1);
                n_status  = ST_OK;
                n_value   = '0;
                n_pos     = '0;
                n_state   = S_EMIT;
            end
            S_RDW: begin
                n_status = ST_OK;
                n_value  = ram_rdata;
                n_pos    = t_pos'({1'b0, r_idx});
                n_state  = S_EMIT;
                if (r_act == ACT_REM_TAIL) begin
                    n_count = r_count - CNT_W'(1);
                end else if (r_act == ACT_REM_HEAD) begin
                    n_count = r_count - CNT_W'(1);
                    if (idx_p1 < r_count) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + ADDR_W'(1);
                        n_state   = S_DOWN;
                    end
                end
            end
            S_DOWN: begin
                // ram_rdata is slot[r_idx+1]; r_count already decremented
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                if (idx_p1 < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + ADDR_W'(2);
                    n_idx     = r_idx + ADDR_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SRCH: begin
                if (ram_rdata == r_elem) begin
                    n_status = ST_OK;
                    n_value  = r_elem;
                    n_pos    = t_pos'({1'b0, r_idx});
                    n_state  = S_EMIT;
                    if (r_act == ACT_REM_VAL) begin
                        n_count = r_count - CNT_W'(1);
                        if (idx_p1 < r_count) begin
                            ram_re    = 1'b1;
                            ram_raddr = r_idx + ADDR_W'(1);
                            n_state   = S_DOWN;
                        end
                    end
                end else if (idx_p1 < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + ADDR_W'(1);
                    n_idx     = r_idx + ADDR_W'(1);
                end else begin
                    n_status = ST_NOTFOUND;
                    n_value  = '0;
                    n_pos    = NO_POS;
                    n_state  = S_EMIT;
                end
            end
            S_ENUM: begin
                // read data holds until the result is taken
                if (i_res_ready) begin
                    if (idx_p1 < r_count) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + ADDR_W'(1);
                        n_idx     = r_idx + ADDR_W'(1);
                    end else begin
                        n_status = ST_OK;
                        n_value  = '0;
                        n_pos    = NO_POS;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= CNT_W'(DEPTH);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cap   <= n_cap;
        end
        r_act    <= n_act;
        r_elem   <= n_elem;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_value  <= n_value;
        r_pos    <= n_pos;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT) || (r_state == S_ENUM);

    always_comb begin
        o_res.status    = (r_state == S_ENUM) ? ST_OK : r_status;
        o_res.value     = (r_state == S_ENUM) ? ram_rdata : r_value;
        o_res.pos       = (r_state == S_ENUM) ? t_pos'({1'b0, r_idx}) : r_pos;
        o_res.last      = (r_state == S_EMIT);
        o_res.is_empty  = empty;
        o_res.is_full   = (r_count == r_cap);
        o_res.occupancy = r_count;
    end

`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("count above capacity");

    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap != '0) && (r_cap <= CNT_W'(DEPTH)))
        else $error("capacity out of range");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) || (r_state == S_EMIT) || (r_state == S_ENUM)) |-> !ram_we)
        else $error("slot write outside an update walk");

    a_mid_result_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> ((o_res.status == ST_OK) && (o_res.pos != NO_POS)))
        else $error("enumerated item without a slot");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res.value)))
        else $error("stalled result changed");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for array_deque_with_search: directed and random actions,
// capacity changes, random stalls on both stream sides. Depends on adq_pkg.
module tb_top
    import adq_pkg::*;
;

    localparam int          LAT        = 24;
    localparam int          LIMIT      = 400000;
    localparam int          PHASES     = 8;
    localparam int          PHASE_LEN  = 62;
    localparam int          POOL       = 5;
    localparam logic [3:0]  ACT_BAD_LO = 4'd9;
    localparam logic [3:0]  ACT_BAD_HI = 4'd15;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // action[3:0], element[35:4], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // status[1:0], value[33:2], position[38:34],
                                 // is_empty[39], is_full[40], occupancy[45:41]
    logic        m_axis_tlast;

    int src_max_gap;
    int snk_max_stall;
    int cycle_count;

    logic [ELEM_W-1:0] word_pool [POOL];

    array_deque_with_search u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // List shadow: predicts the results of each accepted action, checks them in order.
    class deque_tracker;
        logic [ELEM_W-1:0] slots [DEPTH];
        int                count;
        int                capacity;
        t_result           expected_q [$];
        int                errors;
        int                actions_seen;
        int                results_seen;
        int                refusals;
        int                misses;
        int                walks;

        function new();
            count        = 0;
            capacity     = DEPTH;
            errors       = 0;
            actions_seen = 0;
            results_seen = 0;
            refusals     = 0;
            misses       = 0;
            walks        = 0;
        endfunction

        function void apply_capacity(logic [4:0] v);
            if (v == 5'd0) return;
            capacity = (v > DEPTH) ? DEPTH : int'(v);
            count    = 0;
        endfunction

        function void post(t_status st, logic [ELEM_W-1:0] val, t_pos pos, logic lst);
            t_result r;
            r.status    = st;
            r.value     = val;
            r.pos       = pos;
            r.last      = lst;
            r.is_empty  = (count == 0);
            r.is_full   = (count == capacity);
            r.occupancy = CNT_W'(count);
            if (st == ST_NOROOM)   refusals++;
            if (st == ST_NOTFOUND) misses++;
            expected_q.push_back(r);
        endfunction

        function int lowest_match(logic [ELEM_W-1:0] e);
            for (int i = 0; i < count; i++)
                if (slots[i] == e) return i;
            return -1;
        endfunction

        function void note_action(logic [3:0] act, logic [ELEM_W-1:0] e);
            int hit;
            hit = lowest_match(e);
            actions_seen++;
            case (act)
                ACT_ADD_HEAD, ACT_ADD_TAIL: begin
                    if (count >= capacity) begin
                        post(ST_NOROOM, '0, NO_POS, 1'b1);
                    end else if (act == ACT_ADD_HEAD) begin
                        for (int i = count; i > 0; i--) slots[i] = slots[i-1];
                        slots[0] = e;
                        count++;
                        post(ST_OK, '0, t_pos'(0), 1'b1);
                    end else begin
                        slots[count] = e;
                        count++;
                        post(ST_OK, '0, t_pos'(count - 1), 1'b1);
                    end
                end
                ACT_REM_HEAD: begin
                    if (count == 0) begin
                        post(ST_NOTFOUND, '0, NO_POS, 1'b1);
                    end else begin
                        logic [ELEM_W-1:0] v;
                        v = slots[0];
                        count--;
                        for (int i = 0; i < count; i++) slots[i] = slots[i+1];
                        post(ST_OK, v, t_pos'(0), 1'b1);
                    end
                end
                ACT_REM_TAIL: begin
                    if (count == 0) begin
                        post(ST_NOTFOUND, '0, NO_POS, 1'b1);
                    end else begin
                        count--;
                        post(ST_OK, slots[count], t_pos'(count), 1'b1);
                    end
                end
                ACT_REM_VAL: begin
                    if (hit < 0) begin
                        post(ST_NOTFOUND, '0, NO_POS, 1'b1);
                    end else begin
                        count--;
                        for (int i = hit; i < count; i++) slots[i] = slots[i+1];
                        post(ST_OK, e, t_pos'(hit), 1'b1);
                    end
                end
                ACT_HAS_VAL: begin
                    if (hit < 0) post(ST_NOTFOUND, '0, NO_POS, 1'b1);
                    else         post(ST_OK, e, t_pos'(hit), 1'b1);
                end
                ACT_PEEK_HEAD: begin
                    if (count == 0) post(ST_NOTFOUND, '0, NO_POS, 1'b1);
                    else            post(ST_OK, slots[0], t_pos'(0), 1'b1);
                end
                ACT_PEEK_TAIL: begin
                    if (count == 0) post(ST_NOTFOUND, '0, NO_POS, 1'b1);
                    else            post(ST_OK, slots[count-1], t_pos'(count - 1), 1'b1);
                end
                ACT_ENUM: begin
                    walks++;
                    for (int i = 0; i < count; i++) post(ST_OK, slots[i], t_pos'(i), 1'b0);
                    post(ST_OK, '0, NO_POS, 1'b1);
                end
                default: begin
                    post(ST_NOTFOUND, '0, NO_POS, 1'b1);
                end
            endcase
        endfunction

        function void check_field(string what, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [47:0] data, logic lst);
            t_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got data %h last %b",
                         $time, data, lst);
                return;
            end
            want = expected_q.pop_front();
            check_field("status",    ELEM_W'(want.status),    ELEM_W'(data[1:0]));
            check_field("value",     want.value,              data[33:2]);
            check_field("position",  ELEM_W'(want.pos[POS_W-1:0]), ELEM_W'(data[38:34]));
            check_field("last",      ELEM_W'(want.last),      ELEM_W'(lst));
            check_field("is_empty",  ELEM_W'(want.is_empty),  ELEM_W'(data[39]));
            check_field("is_full",   ELEM_W'(want.is_full),   ELEM_W'(data[40]));
            check_field("occupancy", ELEM_W'(want.occupancy), ELEM_W'(data[45:41]));
        endfunction
    endclass

    deque_tracker board;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, LIMIT);
        $display("array_deque_with_search test failed");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, snk_max_stall);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_action(input logic [3:0] act, input logic [ELEM_W-1:0] e);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, e, act};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_action(act, e);
    endtask

    // stop sending, let every pending result come back, then let the core settle
    task automatic settle_list();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.apply_capacity(cap);
        @(posedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: begin
                if (board.count > 0) return board.slots[$urandom_range(0, board.count - 1)];
                return word_pool[$urandom_range(0, POOL - 1)];
            end
            default: return word_pool[$urandom_range(0, POOL - 1)];
        endcase
    endfunction

    task automatic send_random(input int add_pct);
        int          r;
        logic [3:0]  act;
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            act = $urandom_range(0, 1) ? ACT_ADD_HEAD : ACT_ADD_TAIL;
        end else begin
            r = $urandom_range(0, 99);
            if      (r < 30) act = $urandom_range(0, 1) ? ACT_REM_HEAD : ACT_REM_TAIL;
            else if (r < 45) act = ACT_REM_VAL;
            else if (r < 60) act = ACT_HAS_VAL;
            else if (r < 75) act = $urandom_range(0, 1) ? ACT_PEEK_HEAD : ACT_PEEK_TAIL;
            else if (r < 87) act = ACT_ENUM;
            else if (r < 94) act = 4'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
            else             act = 4'($urandom_range(0, 15));
        end
        send_action(act, pick_element());
    endtask

    initial begin : stimulus
        logic [4:0] cap_plan [PHASES];
        int         add_plan [PHASES];
        logic [4:0] cap;
        board = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        src_max_gap   = 5;
        snk_max_stall = 5;
        cap_plan = '{5'd2, 5'd31, 5'd0, 5'd5, 5'd1, 5'd16, 5'd1, 5'd12};
        add_plan = '{40, 60, 30, 45, 40, 55, 40, 20};
        cap_plan[4] = 5'($urandom_range(1, DEPTH));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every lookup and removal misses
        send_action(ACT_PEEK_HEAD, 32'h0);
        send_action(ACT_PEEK_TAIL, 32'h0);
        send_action(ACT_REM_HEAD,  32'h0);
        send_action(ACT_REM_TAIL,  32'h0);
        send_action(ACT_REM_VAL,   32'h0);
        send_action(ACT_HAS_VAL,   32'h0);
        send_action(ACT_ENUM,      32'h0);
        send_action(ACT_BAD_HI,    32'hFFFF_FFFF);
        // duplicates: search and removal hit the lowest slot
        send_action(ACT_ADD_TAIL,  32'h0000_0000);
        send_action(ACT_ADD_HEAD,  32'hFFFF_FFFF);
        send_action(ACT_ADD_TAIL,  32'hFFFF_FFFF);
        send_action(ACT_ADD_HEAD,  32'hA5A5_5A5A);
        send_action(ACT_HAS_VAL,   32'hFFFF_FFFF);
        send_action(ACT_REM_VAL,   32'hFFFF_FFFF);
        send_action(ACT_ENUM,      32'h0);
        send_action(ACT_PEEK_HEAD, 32'h0);
        send_action(ACT_PEEK_TAIL, 32'h0);
        send_action(ACT_HAS_VAL,   32'h1234_5678);
        send_action(ACT_REM_TAIL,  32'h0);
        send_action(ACT_REM_HEAD,  32'h0);
        // single slot: every add after the first is refused
        settle_list();
        write_capacity(5'd1);
        send_action(ACT_ADD_HEAD,  32'h8000_0001);
        send_action(ACT_ADD_TAIL,  32'h0000_0001);
        send_action(ACT_ADD_HEAD,  32'h0000_0002);
        send_action(ACT_ENUM,      32'h0);
        send_action(ACT_BAD_LO,    32'h0);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_list();
            cap = cap_plan[ph];
            write_capacity(cap);
            for (int i = 0; i < POOL; i++) word_pool[i] = $urandom();
            word_pool[0] = (ph % 2) ? 32'hFFFF_FFFF : 32'h0;
            src_max_gap   = (ph % 3 == 1) ? 0 : 5;
            snk_max_stall = (ph % 3 == 1) ? 0 : 5;
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (ph == 3 && k == PHASE_LEN / 2) settle_list();
                send_random(add_plan[ph]);
            end
        end

        settle_list();
        $display("Run covered %0d actions and %0d results, %0d enumerations,",
                 board.actions_seen, board.results_seen, board.walks);
        $display("%0d full refusals and %0d misses, over capacities 1 to 16.",
                 board.refusals, board.misses);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("array_deque_with_search test passed");
        end else begin
            $display("array_deque_with_search test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/adq_pkg.sv
hw/rtl/adq_ram.sv
hw/rtl/adq_core.sv
hw/rtl/array_deque_with_search.sv
test/tb_top.sv
